>>> sv/ussc_pkg.sv
// Shared types and constants for the URL scheme safety check.
// Holds the channel payload structs, the verdict and escape codes and the scan state.
// No dependencies.
package ussc_pkg;

   typedef struct packed {
      logic [7:0] url_byte;
      logic       last_byte;
   } req_type;

   typedef enum logic [1:0] {
      VERDICT_RELATIVE  = 2'd0,
      VERDICT_ALLOWED   = 2'd1,
      VERDICT_UNKNOWN   = 2'd2,
      VERDICT_BACKSLASH = 2'd3
   } verdict_type;

   typedef struct packed {
      logic        url_safe;
      verdict_type verdict;
   } rsp_type;

   typedef enum logic [1:0] {
      ESC_NONE       = 2'd0,
      ESC_AFTER_PCT  = 2'd1,
      ESC_AFTER_HIGH = 2'd2
   } escape_type;

   localparam int SCHEME_LEN_W = 3;
   localparam int WORD_COUNT   = 4;

   typedef struct packed {
      escape_type               escape_phase;
      logic [3:0]               high_nibble;
      logic                     is_decided;
      verdict_type              held_verdict;
      logic                     before_first_letter;
      logic [SCHEME_LEN_W-1:0]  scheme_length;
      logic [WORD_COUNT-1:0]    word_match_flags;
   } scan_state_type;

   localparam scan_state_type SCAN_STATE_RESET = '{
      escape_phase:        ESC_NONE,
      high_nibble:         4'd0,
      is_decided:          1'b0,
      held_verdict:        VERDICT_RELATIVE,
      before_first_letter: 1'b1,
      scheme_length:       '0,
      word_match_flags:    '1
   };

endpackage

>>> sv/ussc_step.sv
// Per-byte update of the URL scan state: percent-escape decode, scheme letter
// matching and verdict logic. Purely combinational. Depends on ussc_pkg.
module ussc_step
   import ussc_pkg::*;
(
   input  scan_state_type cur_state,
   input  req_type        item,
   output scan_state_type nxt_state,
   output rsp_type        result
);

   localparam logic [7:0] CH_PCT   = 8'h25;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_QUEST = 8'h3F;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_BSL   = 8'h5C;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [SCHEME_LEN_W-1:0] SCHEME_LEN_MAX = '1;

   function automatic logic hex_ok(input logic [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
   endfunction

   function automatic logic [3:0] hex_val(input logic [7:0] c);
      logic [7:0] v;
      if (c >= "0" && c <= "9") begin
         v = c - 8'h30;
      end else if (c >= "a" && c <= "f") begin
         v = c - 8'h57;
      end else begin
         v = c - 8'h37;
      end
      return v[3:0];
   endfunction

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic [SCHEME_LEN_W-1:0] word_len(input logic [1:0] w);
      logic [SCHEME_LEN_W-1:0] n;
      case (w)
         2'd0:    n = SCHEME_LEN_W'(4);
         2'd1:    n = SCHEME_LEN_W'(5);
         2'd2:    n = SCHEME_LEN_W'(6);
         default: n = SCHEME_LEN_W'(3);
      endcase
      return n;
   endfunction

   // Character of an allowed scheme word at a position; zero past the word end.
   function automatic logic [7:0] word_char(input logic [1:0] w,
                                            input logic [SCHEME_LEN_W-1:0] pos);
      logic [47:0] text;
      logic [7:0]  ch;
      case (w)
         2'd0:    text = {"http", 16'h0};
         2'd1:    text = {"https", 8'h0};
         2'd2:    text = "mailto";
         default: text = {"ftp", 24'h0};
      endcase
      case (pos)
         3'd0:    ch = text[47:40];
         3'd1:    ch = text[39:32];
         3'd2:    ch = text[31:24];
         3'd3:    ch = text[23:16];
         3'd4:    ch = text[15:8];
         3'd5:    ch = text[7:0];
         default: ch = 8'h0;
      endcase
      return ch;
   endfunction

   logic       take;
   logic [7:0] tbyte;
   logic [7:0] low;
   logic       fits;
   logic       any_match;
   logic [1:0] widx;

   always_comb begin
      nxt_state = cur_state;
      take      = 1'b0;
      tbyte     = item.url_byte;
      low       = 8'h0;
      fits      = 1'b0;
      any_match = 1'b0;
      widx      = 2'd0;

      if (!cur_state.is_decided) begin
         case (cur_state.escape_phase)
            ESC_AFTER_PCT: begin
               if (!hex_ok(item.url_byte) || item.last_byte) begin
                  nxt_state.is_decided   = 1'b1;
                  nxt_state.held_verdict = VERDICT_RELATIVE;
               end else begin
                  nxt_state.high_nibble  = hex_val(item.url_byte);
                  nxt_state.escape_phase = ESC_AFTER_HIGH;
               end
            end
            ESC_AFTER_HIGH: begin
               nxt_state.escape_phase = ESC_NONE;
               if (!hex_ok(item.url_byte)) begin
                  nxt_state.is_decided   = 1'b1;
                  nxt_state.held_verdict = VERDICT_RELATIVE;
               end else begin
                  take  = 1'b1;
                  tbyte = {cur_state.high_nibble, hex_val(item.url_byte)};
               end
            end
            default: begin
               if (item.url_byte == CH_PCT) begin
                  if (item.last_byte) begin
                     nxt_state.is_decided   = 1'b1;
                     nxt_state.held_verdict = VERDICT_RELATIVE;
                  end else begin
                     nxt_state.escape_phase = ESC_AFTER_PCT;
                  end
               end else begin
                  take = 1'b1;
               end
            end
         endcase
      end

      if (take) begin
         fits = is_letter(tbyte) ||
                (!cur_state.before_first_letter &&
                 ((tbyte >= "0" && tbyte <= "9") || tbyte == "+" ||
                  tbyte == "-" || tbyte == "."));
         low  = (tbyte >= "A" && tbyte <= "Z") ? (tbyte + 8'h20) : tbyte;
         for (int w = 0; w < WORD_COUNT; w++) begin
            widx = 2'(w);
            if (cur_state.word_match_flags[w] &&
                cur_state.scheme_length == word_len(widx)) begin
               any_match = 1'b1;
            end
         end

         if (tbyte == CH_COLON) begin
            nxt_state.is_decided = 1'b1;
            if (item.last_byte || cur_state.before_first_letter) begin
               nxt_state.held_verdict = VERDICT_RELATIVE;
            end else if (any_match) begin
               nxt_state.held_verdict = VERDICT_ALLOWED;
            end else begin
               nxt_state.held_verdict = VERDICT_UNKNOWN;
            end
         end else if (tbyte == CH_SLASH || tbyte == CH_QUEST || tbyte == CH_HASH) begin
            nxt_state.is_decided   = 1'b1;
            nxt_state.held_verdict = VERDICT_RELATIVE;
         end else if (tbyte == CH_BSL) begin
            nxt_state.is_decided   = 1'b1;
            nxt_state.held_verdict = VERDICT_BACKSLASH;
         end else if (tbyte <= CH_SPACE) begin
            // Control bytes and spaces are skipped.
         end else if (!fits) begin
            nxt_state.is_decided   = 1'b1;
            nxt_state.held_verdict = VERDICT_RELATIVE;
         end else begin
            nxt_state.before_first_letter = 1'b0;
            for (int w = 0; w < WORD_COUNT; w++) begin
               widx = 2'(w);
               if (!(cur_state.scheme_length < word_len(widx) &&
                     word_char(widx, cur_state.scheme_length) == low)) begin
                  nxt_state.word_match_flags[w] = 1'b0;
               end
            end
            if (cur_state.scheme_length != SCHEME_LEN_MAX) begin
               nxt_state.scheme_length = cur_state.scheme_length + 1'b1;
            end
         end
      end

      result.verdict  = nxt_state.is_decided ? nxt_state.held_verdict : VERDICT_RELATIVE;
      result.url_safe = ~result.verdict[1];
   end

endmodule

>>> sv/url_scheme_safety_check.sv
// Top level of the URL scheme safety check: input register, scan state and
// result register around the per-byte update. Depends on ussc_pkg and ussc_step.
//
// Usage: a link destination enters one byte per transfer on the req_ channel,
// with last_byte set on its final byte. Every byte is taken; only the final
// byte produces a transfer on the rsp_ channel, carrying url_safe and verdict.
// Bytes of the next URL may follow directly on the next cycle.
// The final byte waits in the input register and its verdict is loaded into the
// result register when the byte moves on, which it does once the result
// register is free; the verdict then appears on rsp_.
// Throughput: one byte per cycle unless req_stall is high; the byte's scan state
// update is combinational logic between the input and state registers.
// When the receiver stalls, the result is held in the result register and the
// input register keeps accepting bytes until a second final byte is waiting;
// then req_stall rises until the result register frees up.
// Reset (synchronous, active high) empties both registers and returns the
// scan state to the start of a new URL.
module url_scheme_safety_check
   import ussc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic           in_valid_ff, in_valid_in;
   req_type        in_data_ff, in_data_in;
   scan_state_type state_ff, state_in;
   logic           out_valid_ff, out_valid_in;
   rsp_type        out_data_ff, out_data_in;

   scan_state_type step_state;
   rsp_type        step_result;
   logic           out_free;
   logic           in_go;
   logic           req_take;

   ussc_step u_step (
      .cur_state (state_ff),
      .item      (in_data_ff),
      .nxt_state (step_state),
      .result    (step_result)
   );

   always_comb begin
      out_free  = !out_valid_ff || !rsp_stall;
      in_go     = in_valid_ff && (!in_data_ff.last_byte || out_free);
      req_stall = in_valid_ff && !in_go;
      req_take  = req_valid && !req_stall;

      in_valid_in = in_valid_ff;
      in_data_in  = in_data_ff;
      if (in_go) begin
         in_valid_in = 1'b0;
      end
      if (req_take) begin
         in_valid_in = 1'b1;
         in_data_in  = req_data;
      end

      state_in = state_ff;
      if (in_go) begin
         state_in = in_data_ff.last_byte ? SCAN_STATE_RESET : step_state;
      end

      out_valid_in = out_valid_ff && rsp_stall;
      out_data_in  = out_data_ff;
      if (in_go && in_data_ff.last_byte) begin
         out_valid_in = 1'b1;
         out_data_in  = step_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= SCAN_STATE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
      in_data_ff  <= in_data_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // A waiting result is never overwritten by the next URL's verdict.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && rsp_stall |-> !(in_go && in_data_ff.last_byte))
      else $error("result register overwritten while stalled");

   // After the final byte the scan restarts from the reset state.
   a_scan_restart: assert property (@(posedge clock) disable iff (reset)
      in_go && in_data_ff.last_byte |=> state_ff == SCAN_STATE_RESET)
      else $error("scan state not restarted after final byte");

   // Until a verdict is reached the held verdict stays at its reset code.
   a_undecided_clear: assert property (@(posedge clock) disable iff (reset)
      !state_ff.is_decided |-> state_ff.held_verdict == VERDICT_RELATIVE)
      else $error("held verdict set without a decision");

   // The safe flag agrees with the verdict code.
   a_safe_flag: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> out_data_ff.url_safe ==
         (out_data_ff.verdict == VERDICT_RELATIVE ||
          out_data_ff.verdict == VERDICT_ALLOWED))
      else $error("url_safe disagrees with verdict");

endmodule
